// ----- hw/rtl/one_at_a_time_hash_bucket_unit_assert.svh -----
// Assertion macros for the one-at-a-time hash bucket unit.
// Used by the checker; expects a clock named clk and a reset named rst in scope.
`ifndef ONE_AT_A_TIME_HASH_BUCKET_UNIT_ASSERT_SVH
`define ONE_AT_A_TIME_HASH_BUCKET_UNIT_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define OAAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define OAAT_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/oaat_pkg.sv -----
// Shared types, constants and mixing functions of the one-at-a-time hash unit.
// No dependencies.
`timescale 1ns / 1ps

package oaat_pkg;

  localparam int HASH_WIDTH  = 32;
  localparam int UNIT_WIDTH  = 16;
  // Queue depth between front and back; a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);
  localparam int STEP_WIDTH  = $clog2(HASH_WIDTH);
  // Strings that can be in flight: the queue, the divider and the output register.
  localparam int MAX_PENDING = QUEUE_DEPTH + 2;

  localparam logic [HASH_WIDTH-1:0] UNIT_MASK =
    HASH_WIDTH'((64'd1 << UNIT_WIDTH) - 64'd1);

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        last_unit;
  } in_item_t;

  typedef struct packed {
    logic [31:0] bucket_index;
    logic [31:0] full_hash;
  } out_item_t;

  // Request from the front into the queue.
  typedef struct packed {
    logic                  valid;
    logic [HASH_WIDTH-1:0] hash;
  } queue_entry_t;

  // Per-unit mixing step.
  function automatic logic [HASH_WIDTH-1:0] mix_unit(input logic [HASH_WIDTH-1:0] h_in,
                                                     input logic [HASH_WIDTH-1:0] u);
    logic [HASH_WIDTH-1:0] h;
    h = h_in + u;
    h = h + (h << 10);
    h = h ^ (h >> 6);
    return h;
  endfunction

  // End-of-string mixing.
  function automatic logic [HASH_WIDTH-1:0] finish(input logic [HASH_WIDTH-1:0] h_in);
    logic [HASH_WIDTH-1:0] h;
    h = h_in + (h_in << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

endpackage

// ----- hw/rtl/one_at_a_time_hash_bucket_unit.sv -----
// Top level of the one-at-a-time hash bucket unit: bucket count register,
// front, queue and back. Depends on oaat_pkg, oaat_front, oaat_queue, oaat_back.
//
//   Channel   Signals                              Moves
//   input     in_valid / in_ready / in_data        one code unit per request
//   output    out_valid / out_ready / out_data     bucket index and hash per string
//   config    cfg_wr_en / cfg_wr_data              bucket count, no read-back
//
// A code unit is taken every cycle while the queue has room.
// After its last unit is taken, a string's hash passes through the queue, final
// mixing, the bit-serial divider and the output register; the back starts a new
// string only after it has moved the last one into the output register.
// Reset clears the running hash, the queue and the output; bucket count is 1.
// A stalled output holds the back, then the queue fills and in_ready drops.
`timescale 1ns / 1ps

module one_at_a_time_hash_bucket_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  oaat_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output oaat_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data
);
  import oaat_pkg::*;

  logic [31:0]  bucket_count;
  queue_entry_t push;
  queue_entry_t head;
  logic         queue_full;
  logic         pop;

  // Bucket count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= 32'd1;
    end else if (cfg_wr_en) begin
      bucket_count <= cfg_wr_data;
    end
  end

  oaat_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .queue_full (queue_full)
  );

  oaat_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .head (head),
    .pop  (pop)
  );

  oaat_back u_back (
    .clk          (clk),
    .rst          (rst),
    .bucket_count (bucket_count),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

// ----- hw/rtl/oaat_queue.sv -----
// Short queue of running hashes between the front and the back.
// Depends on oaat_pkg.
`timescale 1ns / 1ps

module oaat_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  oaat_pkg::queue_entry_t push,
  output logic                  full,
  output oaat_pkg::queue_entry_t head,
  input  logic                  pop
);
  import oaat_pkg::*;

  logic [HASH_WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QCNT_WIDTH-1:0] count;

  assign full       = (count == QCNT_WIDTH'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.hash  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (!push.valid && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.hash;
    end
  end

endmodule

// ----- hw/rtl/oaat_front.sv -----
// Front part: accepts code units, mixes them into the running hash and
// queues the hash of each finished string. Depends on oaat_pkg.
`timescale 1ns / 1ps

module oaat_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  oaat_pkg::in_item_t     in_data,
  output oaat_pkg::queue_entry_t push,
  input  logic                   queue_full
);
  import oaat_pkg::*;

  logic [HASH_WIDTH-1:0] running_hash;
  logic [HASH_WIDTH-1:0] mixed;
  logic                  accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // Mix the unit in only when it belongs to the string.
  always_comb begin
    if (in_data.unit_valid) begin
      mixed = mix_unit(running_hash, HASH_WIDTH'(in_data.code_unit) & UNIT_MASK);
    end else begin
      mixed = running_hash;
    end
  end

  assign push.valid = accept && in_data.last_unit;
  assign push.hash  = mixed;

  // The running hash restarts from zero after each string.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (accept) begin
      running_hash <= in_data.last_unit ? '0 : mixed;
    end
  end

endmodule

// ----- hw/rtl/oaat_back.sv -----
// Back part: finalizes a queued hash, takes it modulo the bucket count with a
// bit-serial restoring divider and holds the result request. Depends on oaat_pkg.
`timescale 1ns / 1ps

module oaat_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            bucket_count,
  input  oaat_pkg::queue_entry_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output oaat_pkg::out_item_t    out_data
);
  import oaat_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FINISH,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  state_t                state;
  logic [HASH_WIDTH-1:0] hash_reg;
  logic [HASH_WIDTH-1:0] dividend;
  logic [HASH_WIDTH-1:0] divisor;
  logic [HASH_WIDTH-1:0] remainder;
  logic [STEP_WIDTH-1:0] step;
  logic [HASH_WIDTH:0]   rem_shift;
  logic [HASH_WIDTH:0]   trial;
  logic [HASH_WIDTH-1:0] rem_next;
  logic                  out_free;

  assign pop      = (state == ST_IDLE) && head.valid;
  assign out_free = !out_valid || out_ready;

  // One restoring division step per cycle.
  always_comb begin
    rem_shift = {remainder, dividend[HASH_WIDTH-1]};
    trial     = rem_shift - {1'b0, divisor};
    if (trial[HASH_WIDTH]) begin
      rem_next = rem_shift[HASH_WIDTH-1:0];
    end else begin
      rem_next = trial[HASH_WIDTH-1:0];
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A taken result is dropped unless a new one replaces it this cycle.
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (head.valid) begin
            hash_reg <= head.hash;
            divisor  <= bucket_count;
            state    <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          hash_reg  <= finish(hash_reg);
          dividend  <= finish(hash_reg);
          remainder <= '0;
          step      <= '0;
          state     <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          remainder <= rem_next;
          dividend  <= dividend << 1;
          step      <= step + 1'b1;
          if (step == STEP_WIDTH'(HASH_WIDTH - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid              <= 1'b1;
            out_data.full_hash     <= hash_reg;
            // A zero bucket count has no modulo; the index reads zero.
            out_data.bucket_index  <= (divisor == '0) ? '0 : remainder;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/oaat_checker.sv -----
// Port-level checks of the one-at-a-time hash bucket unit, bound to the top level.
// Depends on oaat_pkg and one_at_a_time_hash_bucket_unit_assert.svh.
`timescale 1ns / 1ps
`include "one_at_a_time_hash_bucket_unit_assert.svh"

module oaat_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input oaat_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input oaat_pkg::out_item_t out_data,
  input logic                cfg_wr_en,
  input logic [31:0]         cfg_wr_data
);
  import oaat_pkg::*;

  localparam int PEND_WIDTH = $clog2(MAX_PENDING + 2);

  logic [PEND_WIDTH-1:0] pending;
  logic [31:0]           shadow_count;
  logic                  last_in;
  logic                  taken_out;

  assign last_in   = in_valid && in_ready && in_data.last_unit;
  assign taken_out = out_valid && out_ready;

  // Strings accepted whose result has not been taken yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (last_in && !taken_out) begin
      pending <= pending + 1'b1;
    end else if (!last_in && taken_out) begin
      pending <= pending - 1'b1;
    end
  end

  // Copy of the bucket count as written on the port.
  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_count <= 32'd1;
    end else if (cfg_wr_en) begin
      shadow_count <= cfg_wr_data;
    end
  end

  `OAAT_ASSERT_ALL(a_reset_clears_out, rst |=> !out_valid, "output valid after reset")
  `OAAT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data),
               "stalled result changed")
  `OAAT_ASSERT(a_no_spurious, out_valid |-> pending != '0, "result without a finished string")
  `OAAT_ASSERT(a_bounded, pending <= PEND_WIDTH'(MAX_PENDING), "too many strings in flight")
  `OAAT_ASSERT(a_index_range,
               out_valid |-> ((shadow_count == '0) ? (out_data.bucket_index == '0)
                                                   : (out_data.bucket_index < shadow_count)),
               "bucket index out of range")

endmodule

bind one_at_a_time_hash_bucket_unit oaat_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_data     (in_data),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_data    (out_data),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data)
);
